/* hdl/hgt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgt_pkg
// Shared types, constants and the binomial table for the hypergeometric tail
// unit.
// ----------------------------------------------------------------------------
package hgt_pkg;

    localparam int ARG_W   = 5;
    localparam int CNT_W   = 18;
    localparam int P_W     = 33;
    localparam int FRAC_W  = 32;
    localparam int TABLE_N = 21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOTAL,
        ST_TERM,
        ST_DIV,
        ST_DONE
    } hgt_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture query
        logic calc_total;
        logic add_term;  // accumulate term for current index, step index
        logic div_start;
        logic div_step;
        logic out_load;
    } hgt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic zero_thr;
        logic last_term; // current index is the final one
        logic div_last;
    } hgt_status_t;

    // C(top, pick) for top <= 20; zero when pick > top or top > 20.
    // Pascal's triangle is built from constants only, so this folds down to
    // a lookup on top and pick.
    function automatic logic [CNT_W-1:0] binom(input logic [ARG_W-1:0] top,
                                               input logic [ARG_W-1:0] pick);
        logic [CNT_W-1:0] row [0:TABLE_N-1];
        logic [CNT_W-1:0] r;
        begin
            r = '0;
            for (int k = 0; k < TABLE_N; k++) row[k] = (k == 0) ? CNT_W'(1) : '0;
            for (int n = 0; n < TABLE_N; n++) begin
                if (n > 0) begin
                    for (int k = TABLE_N - 1; k > 0; k--) row[k] = row[k] + row[k-1];
                end
                if (int'(top) == n && pick <= top) r = row[pick];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/hypergeometric_tail_pvalue_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hypergeometric_tail_pvalue_unit
// Upper-tail hypergeometric p-value with tail and total sample counts.
// ----------------------------------------------------------------------------
// channel | ports                                   | dir
// s_      | valid/ready, population, draws, marked, | in
//         | min_successes                           |
// m_      | valid/ready, p_fixed, tail_count,       | out
//         | total_count, bad_query                  |
// One query at a time: accept, total, tail terms from the threshold index up
// to draws (at least one term), the divider at one quotient bit a cycle, then
// output. Bad queries and zero thresholds skip terms and division.
// aresetn is synchronous; a held result stalls only the final transfer.
// ----------------------------------------------------------------------------
module hypergeometric_tail_pvalue_unit
    import hgt_pkg::*;
#(
    parameter int MAX_POP = 20
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ARG_W-1:0]  s_population,
    input  wire logic [ARG_W-1:0]  s_draws,
    input  wire logic [ARG_W-1:0]  s_marked,
    input  wire logic [ARG_W-1:0]  s_min_successes,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [P_W-1:0]         m_p_fixed,
    output logic [CNT_W-1:0]       m_tail_count,
    output logic [CNT_W-1:0]       m_total_count,
    output logic                   m_bad_query
);

    hgt_cmd_t    cmd;
    hgt_status_t sts;

    hgt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    hgt_dp #(.MAX_POP(MAX_POP)) u_dp (
        .aclk            (aclk),
        .s_population    (s_population),
        .s_draws         (s_draws),
        .s_marked        (s_marked),
        .s_min_successes (s_min_successes),
        .m_p_fixed       (m_p_fixed),
        .m_tail_count    (m_tail_count),
        .m_total_count   (m_total_count),
        .m_bad_query     (m_bad_query),
        .cmd             (cmd),
        .sts             (sts)
    );

    a_p_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_p_fixed <= {1'b1, {FRAC_W{1'b0}}}))
        else $error("p-value above one");

    a_tail_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tail_count <= m_total_count))
        else $error("tail count above total");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_query) |-> (m_total_count == '0 && m_p_fixed == '0))
        else $error("bad query with non-zero result");

endmodule
`default_nettype wire

/* hdl/hgt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgt_ctrl
// Sequencer for one query: total, tail terms, long division, output.
// ----------------------------------------------------------------------------
module hgt_ctrl
    import hgt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output hgt_cmd_t         cmd,
    input  wire hgt_status_t sts
);

    hgt_state_t state_reg, state_next;
    logic       mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        mv_next    = mv_reg;
        if (m_valid && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                cmd.calc_total = 1'b1;
                if (sts.bad || sts.zero_thr) state_next = ST_DONE;
                else                         state_next = ST_TERM;
            end
            ST_TERM: begin
                cmd.add_term = 1'b1;
                if (sts.last_term) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                // result register free once the previous one has gone
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.div_start = (state_reg == ST_TERM) && sts.last_term;
    end

endmodule
`default_nettype wire

/* hdl/hgt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hgt_dp
// Query registers, term accumulator and a restoring divider, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module hgt_dp
    import hgt_pkg::*;
#(
    parameter int MAX_POP = 20
) (
    input  wire logic              aclk,
    input  wire logic [ARG_W-1:0]  s_population,
    input  wire logic [ARG_W-1:0]  s_draws,
    input  wire logic [ARG_W-1:0]  s_marked,
    input  wire logic [ARG_W-1:0]  s_min_successes,
    output logic [P_W-1:0]         m_p_fixed,
    output logic [CNT_W-1:0]       m_tail_count,
    output logic [CNT_W-1:0]       m_total_count,
    output logic                   m_bad_query,
    input  wire hgt_cmd_t          cmd,
    output hgt_status_t            sts
);

    localparam int QW = CNT_W + FRAC_W; // quotient bits of tail*2^32/total

    logic [ARG_W-1:0] pop_reg, drw_reg, mrk_reg, idx_reg;
    logic [CNT_W-1:0] total_reg, tail_reg;
    logic             bad_reg, zero_reg;
    logic [CNT_W-1:0] term_a_reg, term_b_reg;
    logic [CNT_W:0]   rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [5:0]       cnt_reg;
    logic [35:0]      prod;
    logic [CNT_W:0]   rem_sh;
    logic             bit_in;

    assign sts.bad       = bad_reg;
    assign sts.zero_thr  = zero_reg;
    assign sts.last_term = (idx_reg >= drw_reg);
    assign sts.div_last  = (cnt_reg == 6'(QW - 1));

    // binomial table reads are registered, product formed next cycle
    assign prod   = 36'(term_a_reg) * 36'(term_b_reg);
    assign bit_in = quo_reg[QW-1];
    assign rem_sh = {rem_reg[CNT_W-1:0], bit_in};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pop_reg  <= s_population;
            drw_reg  <= s_draws;
            mrk_reg  <= s_marked;
            idx_reg  <= s_min_successes;
            bad_reg  <= (s_draws > s_population) || (s_marked > s_population)
                        || (32'(s_population) > MAX_POP);
            zero_reg <= (s_min_successes == '0);
            tail_reg <= '0;
        end
        if (cmd.calc_total) begin
            total_reg <= binom(pop_reg, drw_reg);
            // terms for idx; mask out when idx > draws
            term_a_reg <= binom(mrk_reg, idx_reg);
            term_b_reg <= (idx_reg > drw_reg) ? '0
                          : binom(pop_reg - mrk_reg, drw_reg - idx_reg);
        end
        if (cmd.add_term) begin
            if (idx_reg <= drw_reg) tail_reg <= tail_reg + prod[CNT_W-1:0];
            idx_reg    <= idx_reg + 5'd1;
            term_a_reg <= binom(mrk_reg, idx_reg + 5'd1);
            term_b_reg <= (idx_reg >= drw_reg) ? '0
                          : binom(pop_reg - mrk_reg, drw_reg - idx_reg - 5'd1);
        end
        if (cmd.div_start) begin
            // dividend bits shift out of the top of quo_reg as quotient enters;
            // the final term lands in tail_reg through add_term this cycle
            quo_reg <= {(idx_reg <= drw_reg) ? tail_reg + prod[CNT_W-1:0]
                        : tail_reg, {FRAC_W{1'b0}}};
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (rem_sh >= {1'b0, total_reg}) begin
                rem_reg <= rem_sh - {1'b0, total_reg};
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            m_bad_query <= bad_reg;
            if (bad_reg) begin
                m_p_fixed     <= '0;
                m_tail_count  <= '0;
                m_total_count <= '0;
            end else if (zero_reg) begin
                m_p_fixed     <= {1'b1, {FRAC_W{1'b0}}};
                m_tail_count  <= total_reg;
                m_total_count <= total_reg;
            end else begin
                m_p_fixed     <= quo_reg[P_W-1:0];
                m_tail_count  <= tail_reg;
                m_total_count <= total_reg;
            end
        end
    end

endmodule
`default_nettype wire

/* tb/sv/tb_hypergeometric_tail_pvalue_unit.sv */
// ----------------------------------------------------------------------------
// tb_hypergeometric_tail_pvalue_unit
// Drives hypergeometric tail queries through the unit and compares p-value,
// tail count, total count and error flag against a local integer predictor.
// ----------------------------------------------------------------------------
module tb_hypergeometric_tail_pvalue_unit
    import hgt_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POP_LIMIT = 20;
    localparam int IDLE_CAP  = 20000;

    typedef struct {
        logic [P_W-1:0]   p_fixed;
        logic [CNT_W-1:0] tail_count;
        logic [CNT_W-1:0] total_count;
        logic             bad_query;
    } tail_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ARG_W-1:0] s_population = '0;
    logic [ARG_W-1:0] s_draws = '0;
    logic [ARG_W-1:0] s_marked = '0;
    logic [ARG_W-1:0] s_min_successes = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [P_W-1:0] m_p_fixed;
    logic [CNT_W-1:0] m_tail_count;
    logic [CNT_W-1:0] m_total_count;
    logic m_bad_query;

    tail_result_t pending_results[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 1'b0;
    longint unsigned fact_tab[0:20];

    always #6 aclk = ~aclk;

    hypergeometric_tail_pvalue_unit #(.MAX_POP(POP_LIMIT)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_population(s_population), .s_draws(s_draws),
        .s_marked(s_marked), .s_min_successes(s_min_successes),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_p_fixed(m_p_fixed), .m_tail_count(m_tail_count),
        .m_total_count(m_total_count), .m_bad_query(m_bad_query)
    );

    function automatic longint unsigned choose(int top, int pick);
        if (top < 0 || pick < 0 || pick > top || top > 20) return 0;
        return fact_tab[top] / (fact_tab[pick] * fact_tab[top - pick]);
    endfunction

    function automatic tail_result_t tail_pvalue(int pop, int drw, int mrk, int thr);
        tail_result_t r;
        longint unsigned total;
        longint unsigned tail;
        tail = 0;
        r.p_fixed = '0;
        r.tail_count = '0;
        r.total_count = '0;
        r.bad_query = 1'b0;
        if (drw > pop || mrk > pop || pop > POP_LIMIT) begin
            r.bad_query = 1'b1;
            return r;
        end
        total = choose(pop, drw);
        r.total_count = total[CNT_W-1:0];
        if (thr == 0) begin
            r.p_fixed = 33'h1_0000_0000;
            r.tail_count = total[CNT_W-1:0];
            return r;
        end
        for (int i = thr; i <= drw; i++)
            tail += choose(mrk, i) * choose(pop - mrk, drw - i);
        r.tail_count = tail[CNT_W-1:0];
        r.p_fixed = (total != 0) ? P_W'((tail << 32) / total) : '0;
        return r;
    endfunction

    // returns at the accepting edge with valid still high; wait_drained drops it at
    // the following falling edge, the next call drops it there only when idling
    task automatic send_query(int pop, int drw, int mrk, int thr);
        @(negedge aclk);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_population <= ARG_W'(pop);
        s_draws <= ARG_W'(drw);
        s_marked <= ARG_W'(mrk);
        s_min_successes <= ARG_W'(thr);
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(tail_pvalue(pop, drw, mrk, thr));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // mostly valid queries, a few out of range, any 5-bit value reachable
    task automatic send_random(int count);
        int pop, drw, mrk;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(9, 0) == 0) begin
                send_query($urandom_range(31, 0), $urandom_range(31, 0),
                           $urandom_range(31, 0), $urandom_range(31, 0));
            end else begin
                pop = ($urandom_range(3, 0) == 0) ? 20 : $urandom_range(20, 0);
                drw = $urandom_range(pop, 0);
                mrk = $urandom_range(pop, 0);
                send_query(pop, drw, mrk, $urandom_range(drw + 1, 0));
            end
        end
    endtask

    task automatic test_directed();
        send_query(0, 0, 0, 0);
        send_query(0, 0, 0, 1);
        send_query(20, 10, 10, 0);
        send_query(20, 10, 10, 1);
        send_query(20, 10, 10, 6);
        send_query(20, 10, 10, 10);
        send_query(20, 10, 10, 11);
        send_query(20, 20, 20, 20);
        send_query(20, 20, 0, 1);
        send_query(20, 1, 20, 1);
        send_query(20, 19, 3, 2);
        send_query(20, 10, 3, 31);
        send_query(21, 0, 0, 0);
        send_query(31, 31, 31, 31);
        send_query(5, 6, 0, 1);
        send_query(5, 2, 6, 1);
        send_query(15, 8, 7, 3);
        send_query(10, 5, 5, 5);
        send_query(1, 1, 1, 1);
        send_query(20, 0, 10, 0);
        send_query(20, 0, 10, 1);
        wait_drained();
    endtask

    task automatic test_idle_mix();
        int pattern[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{18, 18}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = pattern[ph][0];
            recv_stall_pct = pattern[ph][1];
            send_random(110);
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (600) @(negedge aclk);
                recv_hold = 1'b0;
            end
            send_random(40);
        join
        wait_drained();
    endtask

    always @(negedge aclk) begin
        m_ready <= !recv_hold &&
                   !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        tail_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no query outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_p_fixed !== want.p_fixed) begin
                    $error("p_fixed exp %0d got %0d", want.p_fixed, m_p_fixed);
                    fail_count++;
                end
                if (m_tail_count !== want.tail_count) begin
                    $error("tail_count exp %0d got %0d", want.tail_count, m_tail_count);
                    fail_count++;
                end
                if (m_total_count !== want.total_count) begin
                    $error("total_count exp %0d got %0d", want.total_count, m_total_count);
                    fail_count++;
                end
                if (m_bad_query !== want.bad_query) begin
                    $error("bad_query exp %0d got %0d", want.bad_query, m_bad_query);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_CAP) begin
            $display("tb_hypergeometric_tail_pvalue_unit: errors");
            $finish;
        end
    end

    initial begin
        fact_tab[0] = 1;
        for (int k = 1; k <= 20; k++) fact_tab[k] = fact_tab[k - 1] * k;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_idle_mix();
        test_backpressure();
        wait_drained();
        repeat (100) @(negedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_hypergeometric_tail_pvalue_unit: clean");
        else
            $display("tb_hypergeometric_tail_pvalue_unit: errors");
        $finish;
    end

endmodule
